>>> design/wmm_pkg.sv
// wmm_pkg: types, constants and reduction helpers shared by the
// window min/max filter modules. No dependencies.
package wmm_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int COL_W      = 13;
    localparam int RAD_W      = 4;
    localparam int MASK_W     = 4;
    localparam int PEND_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int RED_N      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 3'd3;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [MASK_W-1:0]     RST_MASK   = 4'd3;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;
    localparam logic MODE_MIN  = 1'b0;
    localparam logic MODE_MAX  = 1'b1;

    localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;
    localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel_in;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic             frame_end;
    } t_res;

    // one shift of the window, real or padding sample
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             in_win;
        logic             frame_end;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
    } t_step;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic             mode;
    } t_win_cfg;

    typedef enum logic [1:0] {
        FS_RUN,
        FS_PAD,
        FS_DRAIN
    } t_fstate;

    function automatic logic [PIX_W-1:0] wmm_neutral(input logic mode);
        return (mode == MODE_MAX) ? PIX_LOW : PIX_HIGH;
    endfunction

    function automatic logic [PIX_W-1:0] wmm_pick(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic mode);
        if (mode == MODE_MAX) begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

    // balanced tree over RED_N samples
    function automatic logic [PIX_W-1:0] wmm_reduce(
        input logic [RED_N-1:0][PIX_W-1:0] vals,
        input logic mode
    );
        logic [RED_N-1:0][PIX_W-1:0] v;
        v = vals;
        for (int span = RED_N >> 1; span >= 1; span = span >> 1) begin
            for (int i = 0; i < span; i++) begin
                v[i] = wmm_pick(v[2*i], v[2*i+1], mode);
            end
        end
        return v[0];
    endfunction

endpackage

>>> design/wmm_fifo.sv
// wmm_fifo: small register queue with occupancy count.
// Depends on nothing; used for the step queue and the result queue.
module wmm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + PW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

>>> design/wmm_front.sv
// wmm_front: configuration registers, raster position tracking and drain
// sequencing. Emits a window step per pixel, flush or pad. Uses wmm_pkg.
module wmm_front
    import wmm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_MASK   = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_req                  i_req,
    output logic                  o_full,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output logic                  o_step_push,
    output t_step                 o_step,
    input  logic                  i_step_full,
    output t_win_cfg              o_win_cfg
);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int KW   = WW + HW + 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int RMAX = MAX_MASK / 2;

    logic [CFG_DATA_W-1:0] r_width, r_height;
    logic [MASK_W-1:0]     r_mask;
    logic                  r_mode;
    t_fstate               r_state, n_state;
    logic [CW-1:0]         r_col, n_col, r_res_col, n_res_col;
    logic [RW-1:0]         r_res_row, n_res_row;
    logic [KW-1:0]         r_k, n_k, r_done, n_done;
    logic [PEND_W-1:0]     r_pend, n_pend;

    logic [WW-1:0]     w;
    logic [HW-1:0]     h;
    logic [RAD_W-1:0]  rad;
    logic [KW-1:0]     total, lag, done_next;
    logic [PEND_W-1:0] pend_frame;
    logic              cfg_wr, acc, pix_acc, fl_acc, last_pix, emit_pix;
    logic              res_inside, res_fend, res_wrap;
    logic [CW-1:0]     col_inc;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_FILTER_MODE);

    always_comb begin
        if (r_width == '0) begin
            w = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_width);
        end
        if (r_height == '0) begin
            h = HW'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(r_height);
        end
        if (32'(r_mask[MASK_W-1:1]) > RMAX) begin
            rad = RAD_W'(RMAX);
        end else begin
            rad = RAD_W'(r_mask[MASK_W-1:1]);
        end
    end

    assign total = KW'(w) * KW'(h);
    assign lag   = KW'(rad) * KW'(w) + KW'(rad);

    assign acc      = i_push && !o_full;
    assign pix_acc  = acc && (i_req.req_type == REQ_PIXEL);
    assign fl_acc   = acc && (i_req.req_type == REQ_FLUSH);
    assign last_pix = (r_k >= total - KW'(1));
    assign emit_pix = (r_k >= lag);
    assign done_next  = r_done + KW'(emit_pix);
    assign pend_frame = (done_next >= total) ? '0 : PEND_W'(total - done_next);
    assign col_inc    = (KW'(r_col) + KW'(1) >= KW'(w)) ? '0 : r_col + CW'(1);
    assign res_wrap   = (KW'(r_res_col) + KW'(1) >= KW'(w));

    assign res_inside = (rad != '0)
                     && (KW'(r_res_row) >= KW'(rad))
                     && (KW'(r_res_col) >= KW'(rad))
                     && (KW'(r_res_row) + KW'(rad) <= KW'(h) - KW'(1))
                     && (KW'(r_res_col) + KW'(rad) <= KW'(w) - KW'(1));
    assign res_fend   = (KW'(r_res_col) == KW'(w) - KW'(1))
                     && (KW'(r_res_row) == KW'(h) - KW'(1));

    assign o_full    = (r_state == FS_PAD) || i_step_full;
    assign o_win_cfg = '{radius: rad, mode: r_mode};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_RUN: begin
                if (pix_acc && last_pix && pend_frame != '0) begin
                    n_state = (total < lag) ? FS_PAD : FS_DRAIN;
                end
            end
            FS_PAD: begin
                if (!i_step_full && (r_k + KW'(1) >= lag)) begin
                    n_state = FS_DRAIN;
                end
            end
            FS_DRAIN: begin
                if (fl_acc && r_pend == PEND_W'(1)) begin
                    n_state = FS_RUN;
                end
            end
            default: n_state = FS_RUN;
        endcase
        if (cfg_wr) begin
            n_state = FS_RUN;
        end
    end

    // step generation and counters
    always_comb begin
        n_col     = r_col;
        n_k       = r_k;
        n_done    = r_done;
        n_pend    = r_pend;
        n_res_col = r_res_col;
        n_res_row = r_res_row;
        o_step_push       = 1'b0;
        o_step.pix        = i_req.pixel_in;
        o_step.col        = COL_W'(r_col);
        o_step.emit       = 1'b0;
        o_step.in_win     = res_inside;
        o_step.frame_end  = res_fend;
        o_step.out_col    = POS_W'(r_res_col);
        o_step.out_row    = POS_W'(r_res_row);
        case (r_state)
            FS_RUN: begin
                if (pix_acc) begin
                    o_step_push = 1'b1;
                    o_step.emit = emit_pix;
                    n_col = col_inc;
                    n_k   = r_k + KW'(1);
                    if (emit_pix) begin
                        n_done    = done_next;
                        n_res_col = res_wrap ? '0 : r_res_col + CW'(1);
                        n_res_row = res_wrap ? r_res_row + RW'(1) : r_res_row;
                    end
                    if (last_pix) begin
                        // padding continues the linear count past the frame
                        n_k    = (pend_frame != '0) ? total : '0;
                        n_pend = pend_frame;
                        if (done_next >= total) begin
                            n_done    = '0;
                            n_res_col = '0;
                            n_res_row = '0;
                        end
                    end
                end
            end
            FS_PAD: begin
                if (!i_step_full) begin
                    o_step_push = 1'b1;
                    n_col = col_inc;
                    n_k   = r_k + KW'(1);
                end
            end
            FS_DRAIN: begin
                if (fl_acc) begin
                    o_step_push = 1'b1;
                    o_step.emit = 1'b1;
                    n_col     = col_inc;
                    n_pend    = r_pend - PEND_W'(1);
                    n_res_col = res_wrap ? '0 : r_res_col + CW'(1);
                    n_res_row = res_wrap ? r_res_row + RW'(1) : r_res_row;
                    if (r_pend == PEND_W'(1)) begin
                        n_col     = '0;
                        n_k       = '0;
                        n_done    = '0;
                        n_res_col = '0;
                        n_res_row = '0;
                    end
                end
            end
            default: ;
        endcase
        if (cfg_wr) begin
            n_col     = '0;
            n_k       = '0;
            n_done    = '0;
            n_pend    = '0;
            n_res_col = '0;
            n_res_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
            r_mask    <= RST_MASK;
            r_mode    <= MODE_MIN;
            r_state   <= FS_RUN;
            r_col     <= '0;
            r_k       <= '0;
            r_done    <= '0;
            r_pend    <= '0;
            r_res_col <= '0;
            r_res_row <= '0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_k       <= n_k;
            r_done    <= n_done;
            r_pend    <= n_pend;
            r_res_col <= n_res_col;
            r_res_row <= n_res_row;
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_IMG_WIDTH:   r_width  <= i_cfg_data;
                    CFG_IMG_HEIGHT:  r_height <= i_cfg_data;
                    CFG_MASK_SIZE:   r_mask   <= i_cfg_data[MASK_W-1:0];
                    CFG_FILTER_MODE: r_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_RUN) == (r_pend == '0))
        else $error("drain state and pending count disagree");

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step_push |-> !i_step_full)
        else $error("step pushed into a full queue");

endmodule

>>> design/wmm_back.sv
// wmm_back: line stores, column and row min/max reduction and the result
// queue. Executes steps from the front queue. Uses wmm_pkg and wmm_fifo.
module wmm_back
    import wmm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_MASK  = 15
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step_empty,
    input  t_step    i_step,
    output logic     o_step_pop,
    input  t_win_cfg i_win_cfg,
    input  logic     i_pop,
    output logic     o_empty,
    output t_res     o_res
);
    localparam int RMAX      = MAX_MASK / 2;
    localparam int LB_ROWS   = (RMAX > 0) ? 2 * RMAX : 1;
    localparam int LBW       = LB_ROWS * PIX_W;
    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int WIN_N     = 2 * RMAX + 1;
    localparam int RES_DEPTH = 8;
    localparam int RCW       = $clog2(RES_DEPTH + 1);

    logic [LBW-1:0]   r_mem [MAX_WIDTH];
    logic [LBW-1:0]   r_rd, wdata;
    logic [AW-1:0]    raddr, waddr;
    logic             r_s1_valid, r_s2_valid;
    t_step            r_s1, r_s2;
    logic [PIX_W-1:0] r_colsh [WIN_N];
    logic [PIX_W-1:0] r_ctr [RMAX+1];

    logic [PIX_W-1:0] smp [WIN_N];
    logic [RED_N-1:0][PIX_W-1:0] col_vals, win_vals;
    logic [PIX_W-1:0] col_red, ctr_smp, win_red, ctr_sel, neutral;
    logic             res_full, res_push;
    logic [RCW-1:0]   res_count;
    logic [RCW:0]     committed;
    t_res             res_word;
    logic [$bits(t_res)-1:0] res_rdata;

    assign neutral   = wmm_neutral(i_win_cfg.mode);
    assign committed = (RCW+1)'(res_count) + (RCW+1)'(r_s1_valid && r_s1.emit)
                     + (RCW+1)'(r_s2_valid && r_s2.emit);
    assign o_step_pop = !i_step_empty && (committed < (RCW+1)'(RES_DEPTH));

    assign raddr = i_step.col[AW-1:0];
    assign waddr = r_s1.col[AW-1:0];

    // line store: row 0 is the newest line
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[waddr] <= wdata;
        end
        if (r_s1_valid && waddr == raddr) begin
            r_rd <= wdata;
        end else begin
            r_rd <= r_mem[raddr];
        end
    end

    always_comb begin
        wdata = r_rd;
        wdata[PIX_W-1:0] = r_s1.pix;
        for (int j = 1; j < LB_ROWS; j++) begin
            wdata[j*PIX_W +: PIX_W] = r_rd[(j-1)*PIX_W +: PIX_W];
        end
    end

    // column reduction over rows y-2r .. y
    always_comb begin
        smp[0] = r_s1.pix;
        for (int j = 1; j < WIN_N; j++) begin
            smp[j] = r_rd[(j-1)*PIX_W +: PIX_W];
        end
        col_vals = {RED_N{neutral}};
        ctr_smp  = smp[0];
        for (int j = 0; j < WIN_N; j++) begin
            if ((RAD_W+1)'(j) <= {i_win_cfg.radius, 1'b0}) begin
                col_vals[j] = smp[j];
            end
            if (RAD_W'(j) == i_win_cfg.radius) begin
                ctr_smp = smp[j];
            end
        end
        col_red = wmm_reduce(col_vals, i_win_cfg.mode);
    end

    // row reduction over the last 2r+1 columns
    always_comb begin
        win_vals = {RED_N{neutral}};
        for (int j = 0; j < WIN_N; j++) begin
            if ((RAD_W+1)'(j) <= {i_win_cfg.radius, 1'b0}) begin
                win_vals[j] = r_colsh[j];
            end
        end
        win_red = wmm_reduce(win_vals, i_win_cfg.mode);
        ctr_sel = r_ctr[0];
        for (int j = 0; j <= RMAX; j++) begin
            if (RAD_W'(j) == i_win_cfg.radius) begin
                ctr_sel = r_ctr[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_step_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= i_step;
        r_s2 <= r_s1;
        if (r_s1_valid) begin
            r_colsh[0] <= col_red;
            r_ctr[0]   <= ctr_smp;
            for (int j = 1; j < WIN_N; j++) begin
                r_colsh[j] <= r_colsh[j-1];
            end
            for (int j = 1; j <= RMAX; j++) begin
                r_ctr[j] <= r_ctr[j-1];
            end
        end
    end

    assign res_push           = r_s2_valid && r_s2.emit;
    assign res_word.pixel_out = r_s2.in_win ? win_red : ctr_sel;
    assign res_word.out_col   = r_s2.out_col;
    assign res_word.out_row   = r_s2.out_row;
    assign res_word.frame_end = r_s2.frame_end;

    wmm_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_word),
        .o_full  (res_full),
        .i_rd    (i_pop),
        .o_rdata (res_rdata),
        .o_empty (o_empty),
        .o_count (res_count)
    );

    assign o_res = t_res'(res_rdata);

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result lost on a full queue");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= (RCW+1)'(RES_DEPTH))
        else $error("results in flight exceed queue space");

endmodule

>>> design/window_min_max_filter.sv
// window_min_max_filter: streaming erosion/dilation over a square window.
// Depends on wmm_pkg, wmm_front, wmm_fifo and wmm_back.
//
//  channel   handshake              payload
//  input     i_push / o_full        i_req  (req_type, pixel_in)
//  result    o_empty / i_pop        o_res  (pixel_out, out_col, out_row, frame_end)
//  config    i_cfg_valid / ready    i_cfg_index, i_cfg_data
//
// One item per cycle while o_full is low; a result passes through the step
// queue, the s1 and s2 registers and the result queue, with a line-store
// memory read per item. When a frame is shorter than the window lag, the
// first flush waits for line-store padding up to that lag before it is taken.
// Synchronous active-low reset; the line stores are not cleared.
// A full result queue holds back the step queue, which then raises o_full.
module window_min_max_filter
    import wmm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_MASK   = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_req                  i_req,
    output logic                  o_full,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_res                  o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int STEP_DEPTH = 4;

    logic     step_push, step_full, step_pop, step_empty;
    t_step    step_in;
    t_win_cfg win_cfg;
    logic [$bits(t_step)-1:0] step_rdata;
    logic [$clog2(STEP_DEPTH+1)-1:0] step_count;

    wmm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_MASK   (MAX_MASK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_req       (i_req),
        .o_full      (o_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_step_push (step_push),
        .o_step      (step_in),
        .i_step_full (step_full),
        .o_win_cfg   (win_cfg)
    );

    wmm_fifo #(
        .WIDTH ($bits(t_step)),
        .DEPTH (STEP_DEPTH)
    ) u_step_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (step_push),
        .i_wdata (step_in),
        .o_full  (step_full),
        .i_rd    (step_pop),
        .o_rdata (step_rdata),
        .o_empty (step_empty),
        .o_count (step_count)
    );

    wmm_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_MASK  (MAX_MASK)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_empty (step_empty),
        .i_step       (t_step'(step_rdata)),
        .o_step_pop   (step_pop),
        .i_win_cfg    (win_cfg),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_res        (o_res)
    );

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_empty == (step_count == '0))
        else $error("step queue count and empty flag disagree");

endmodule
